>>> rtl/core/dsta_pkg.sv
// Shared types, constants and the in-tile swizzle for the depth surface tile addresser.
// No dependencies.
package dsta_pkg;

	localparam int TileEdge       = 128;
	localparam int MaxExtentDflt  = 16384;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 15;

	localparam logic [CfgIdxW-1:0] CfgWidth     = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgHeight    = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgDirection = 2'd2;

	localparam logic [3:0] BytesPair   = 4'd8;
	localparam logic [3:0] BytesSingle = 4'd4;
	localparam logic [3:0] BytesNone   = 4'd0;

	typedef struct packed {
		logic load;      // latch a new request
		logic setup;     // compute bases and pixel count
		logic emit;      // emit one descriptor (pair or odd single) and advance x
		logic emit_bad;  // emit the rejection word
	} dsta_cmd_t;

	typedef struct packed {
		logic bad;   // request lies outside the surface
		logic last;  // current x is the final descriptor of the run
	} dsta_status_t;

	// In-tile byte offset of pixel (x, y) within a 128x128 tile.
	function automatic logic [15:0] swizzle(input logic [6:0] x, input logic [6:0] y);
		logic [6:0]  xy;
		logic [15:0] s;
		xy = x ^ y;
		s = '0;
		s[2]  = x[0];
		s[3]  = y[0];
		s[4]  = x[1];
		s[5]  = y[1];
		s[6]  = x[2];
		s[7]  = y[2];
		s[8]  = xy[3];
		s[9]  = xy[4];
		s[10] = y[5] ^ x[6];
		s[11] = x[5] ^ y[6];
		s[12] = y[3];
		s[13] = x[4];
		s[14] = y[6];
		s[15] = x[6];
		return s;
	endfunction

endpackage

>>> rtl/core/depth_surface_tile_copy_addresser_core.sv
// Top level of the depth surface tile addresser: configuration registers,
// sequencer and offset datapath. Depends on dsta_pkg, dsta_ctrl, dsta_datapath.
//
// One request (row_index, block_column) is taken when start is high and busy
// is low. The block then emits one copy word per pixel pair of that row
// segment of up to 128 pixels on result_strobe, one word per cycle, with a
// 4-byte word for an odd last pixel and last_of_run on the final word. A
// request outside the surface (or any request while width or height is 0 or
// above MAX_EXTENT) gives a single word with bad_request set. The receiver
// cannot stall: each word is on the outputs for exactly one cycle. Sequence:
// after the accept edge the setup state computes the row base (one 14x15
// multiply) and tile index; the run state then registers the words one per
// cycle, and busy is high through setup and run, or setup alone for a
// rejection. The next request can be taken in the cycle the last word is on
// the outputs. Configuration is written through wr_en/wr_index/wr_data while
// idle; index 3 is ignored.
module depth_surface_tile_copy_addresser_core import dsta_pkg::*; #(
	parameter int MAX_EXTENT = MaxExtentDflt
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	input  logic                start,
	output logic                busy,
	input  logic [13:0]         row_index,
	input  logic [6:0]          block_column,
	output logic                result_strobe,
	output logic [29:0]         source_offset,
	output logic [29:0]         dest_offset,
	output logic [3:0]          byte_count,
	output logic                last_of_run,
	output logic                bad_request
);

	logic [CfgDataW-1:0] width_q;
	logic [CfgDataW-1:0] height_q;
	logic                direction_q;

	dsta_cmd_t    cmd;
	dsta_status_t status;

	// Configuration registers; hold unless written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CfgDataW'(1);
			height_q    <= CfgDataW'(1);
			direction_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				CfgWidth:     width_q     <= wr_data;
				CfgHeight:    height_q    <= wr_data;
				CfgDirection: direction_q <= wr_data[0];
				default:      ;
			endcase
		end
	end

	dsta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	dsta_datapath #(
		.MAX_EXTENT (MAX_EXTENT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.row_index     (row_index),
		.block_column  (block_column),
		.cfg_width     (width_q),
		.cfg_height    (height_q),
		.cfg_direction (direction_q),
		.result_strobe (result_strobe),
		.source_offset (source_offset),
		.dest_offset   (dest_offset),
		.byte_count    (byte_count),
		.last_of_run   (last_of_run),
		.bad_request   (bad_request)
	);

	// A rejection word is always the whole run and carries no bytes
	a_bad_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && bad_request |-> last_of_run && (byte_count == BytesNone))
		else $error("rejection word malformed");

	// A good word moves a pair or a single pixel
	a_good_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !bad_request |->
			(byte_count == BytesPair) || (byte_count == BytesSingle))
		else $error("bad byte count on good word");

	// A single pixel word only ends a run
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (byte_count == BytesSingle) |-> last_of_run)
		else $error("single pixel word before end of run");

	// Words inside a run appear only while the request is still held
	a_mid_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_run |-> busy)
		else $error("mid-run word while idle");

	// The setup cycle after an accept never carries a word
	a_setup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe)
		else $error("word during setup");

endmodule

>>> rtl/core/dsta_ctrl.sv
// Sequencer for the depth surface tile addresser: accept, setup, run.
// Depends on dsta_pkg.
module dsta_ctrl import dsta_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  dsta_status_t status,
	output dsta_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= status.bad ? ST_IDLE : ST_RUN;
				end
				ST_RUN: begin
					if (status.last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.setup    = (state_q == ST_SETUP);
		cmd.emit_bad = (state_q == ST_SETUP) && status.bad;
		cmd.emit     = (state_q == ST_RUN);
	end

endmodule

>>> rtl/core/dsta_datapath.sv
// Offset datapath for the depth surface tile addresser: bases, pixel walk, result word.
// Depends on dsta_pkg.
module dsta_datapath import dsta_pkg::*; #(
	parameter int MAX_EXTENT = MaxExtentDflt
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dsta_cmd_t           cmd,
	output dsta_status_t        status,
	input  logic [13:0]         row_index,
	input  logic [6:0]          block_column,
	input  logic [CfgDataW-1:0] cfg_width,
	input  logic [CfgDataW-1:0] cfg_height,
	input  logic                cfg_direction,
	output logic                result_strobe,
	output logic [29:0]         source_offset,
	output logic [29:0]         dest_offset,
	output logic [3:0]          byte_count,
	output logic                last_of_run,
	output logic                bad_request
);

	localparam logic [CfgDataW-1:0] MaxExt = CfgDataW'(MAX_EXTENT);

	logic [13:0] y_q;
	logic [6:0]  blk_q;
	logic [29:0] row_base_q;
	logic [13:0] tile_idx_q;
	logic [7:0]  count_q;
	logic [7:0]  x_q;

	logic [15:0] bpr_sum;
	logic [8:0]  bpr;
	logic        ext_ok;
	logic [28:0] row_prod;
	logic [14:0] tile_idx;
	logic [15:0] rem;
	logic [7:0]  count;
	logic        is_last;
	logic        is_pair;
	logic [29:0] lin_off;
	logic [29:0] til_off;

	always_comb begin
		bpr_sum  = 16'(cfg_width) + 16'(TileEdge - 1);
		bpr      = bpr_sum[15:7];
		ext_ok   = (cfg_width != '0) && (cfg_width <= MaxExt) &&
		           (cfg_height != '0) && (cfg_height <= MaxExt);
		row_prod = 29'(y_q) * 29'(cfg_width);
		tile_idx = 15'(y_q[13:7]) * 15'(bpr[7:0]) + 15'(blk_q);
		rem      = 16'(cfg_width) - 16'({blk_q, 7'b0});
		count    = (rem < 16'(TileEdge)) ? rem[7:0] : 8'(TileEdge);
		is_last  = (9'(x_q) + 9'd2) >= 9'(count_q);
		is_pair  = (9'(x_q) + 9'd1) < 9'(count_q);
		lin_off  = row_base_q + 30'({x_q, 2'b00});
		til_off  = {tile_idx_q, swizzle(x_q[6:0], y_q[6:0])};
	end

	assign status.bad  = !ext_ok || (15'(y_q) >= cfg_height) || (9'(blk_q) >= bpr);
	assign status.last = is_last;

	// Request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q   <= row_index;
			blk_q <= block_column;
		end
		if (cmd.setup) begin
			row_base_q <= 30'({row_prod, 2'b00}) + 30'({blk_q, 9'b0});
			tile_idx_q <= tile_idx[13:0];
			count_q    <= count;
			x_q        <= '0;
		end else if (cmd.emit) begin
			x_q <= x_q + 8'd2;
		end
	end

	// Result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit || cmd.emit_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bad) begin
			source_offset <= '0;
			dest_offset   <= '0;
			byte_count    <= BytesNone;
			last_of_run   <= 1'b1;
			bad_request   <= 1'b1;
		end else if (cmd.emit) begin
			source_offset <= cfg_direction ? lin_off : til_off;
			dest_offset   <= cfg_direction ? til_off : lin_off;
			byte_count    <= is_pair ? BytesPair : BytesSingle;
			last_of_run   <= is_last;
			bad_request   <= 1'b0;
		end
	end

endmodule

>>> sim/depth_surface_tile_copy_addresser_core_tb.sv
// Self-checking testbench for depth_surface_tile_copy_addresser_core: row/block requests in,
// copy descriptor words out, checked against an in-bench prediction of the tiling swizzle.
// Depends on dsta_pkg and the core RTL only.
`timescale 1ns / 1ps

module depth_surface_tile_copy_addresser_core_tb;
	import dsta_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;  // no register behind this index
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 8;
	localparam longint unsigned OffsetMask = 64'h3FFF_FFFF;

	typedef enum {STEP_REQUEST, STEP_WRITE, STEP_SETTLE} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [CfgIdxW-1:0]  idx;
		logic [CfgDataW-1:0] data;
		logic [13:0]         row;
		logic [6:0]          blk;
		int                  idle_pct;
	} step_t;

	typedef struct packed {
		logic [29:0] src;
		logic [29:0] dst;
		logic [3:0]  bytes;
		logic        last;
		logic        bad;
	} descriptor_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                wr_en = 1'b0;
	logic [CfgIdxW-1:0]  wr_index = '0;
	logic [CfgDataW-1:0] wr_data = '0;
	logic                start = 1'b0;
	logic [13:0]         row_index = '0;
	logic [6:0]          block_column = '0;
	logic                busy;
	logic                result_strobe;
	logic [29:0]         source_offset;
	logic [29:0]         dest_offset;
	logic [3:0]          byte_count;
	logic                last_of_run;
	logic                bad_request;

	depth_surface_tile_copy_addresser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.start        (start),
		.busy         (busy),
		.row_index    (row_index),
		.block_column (block_column),
		.result_strobe(result_strobe),
		.source_offset(source_offset),
		.dest_offset  (dest_offset),
		.byte_count   (byte_count),
		.last_of_run  (last_of_run),
		.bad_request  (bad_request)
	);

	// Work waiting to be driven, and descriptor words the block still owes us.
	step_t       pending_steps[$];
	descriptor_t owed_descriptors[$];

	// Bench copy of the configuration, updated when the write is put on the port.
	logic [14:0] cfg_width = 15'd1;
	logic [14:0] cfg_height = 15'd1;
	logic        cfg_tile_dir = 1'b0;

	// issued is touched only by the driver, checked only by the monitor (nonblocking),
	// so either side reads a stable count of the other.
	int issued_words = 0;
	int checked_words = 0;
	int errors = 0;
	int cycles = 0;

	// Values the stimulus generator assumes, so valid rows and blocks can be chosen.
	int plan_width = 1;
	int plan_height = 1;

	initial begin
		forever #10 clk = ~clk;
	end

	// In-tile byte offset: low x/y bits interleave from bit 2, middle bits fold with XOR, top bits copy x/y.
	function automatic logic [15:0] tile_swizzle(input logic [6:0] px, input logic [6:0] py);
		logic [6:0] mix;
		mix = px ^ py;
		return {px[6], py[6], px[4], py[3], px[5] ^ py[6], py[5] ^ px[6], mix[4], mix[3],
			py[2], px[2], py[1], px[1], py[0], px[0], 2'b00};
	endfunction

	// Work out every descriptor word one accepted request produces and queue them up.
	task automatic plan_descriptors(input logic [13:0] row, input logic [6:0] blk);
		int unsigned     blocks_per_row;
		int unsigned     span;
		longint unsigned row_base;
		longint unsigned tile_base;
		longint unsigned lin;
		longint unsigned til;
		descriptor_t     d;
		logic            extent_ok;
		extent_ok = cfg_width >= 1 && cfg_width <= MaxExtentDflt &&
			cfg_height >= 1 && cfg_height <= MaxExtentDflt;
		blocks_per_row = (int'(cfg_width) + TileEdge - 1) / TileEdge;
		if (!extent_ok || row >= cfg_height || blk >= blocks_per_row) begin
			// Rejection: a single zeroed word with last and bad set.
			d.src = '0;
			d.dst = '0;
			d.bytes = BytesNone;
			d.last = 1'b1;
			d.bad = 1'b1;
			owed_descriptors.push_back(d);
			issued_words++;
		end else begin
			span = int'(cfg_width) - int'(blk) * TileEdge;
			if (span > TileEdge)
				span = TileEdge;
			row_base = longint'(row) * longint'(cfg_width) * 4 + longint'(blk) * TileEdge * 4;
			tile_base = (longint'(row / TileEdge) * blocks_per_row + blk) * 65536;
			for (int unsigned px = 0; px < span; px += 2) begin
				lin = (row_base + longint'(px) * 4) & OffsetMask;
				til = (tile_base + tile_swizzle(px[6:0], row[6:0])) & OffsetMask;
				d.src = cfg_tile_dir ? lin[29:0] : til[29:0];
				d.dst = cfg_tile_dir ? til[29:0] : lin[29:0];
				// An odd pixel left at the end moves on its own.
				d.bytes = (px + 1 < span) ? BytesPair : BytesSingle;
				d.last = (px + 2 >= span);
				d.bad = 1'b0;
				owed_descriptors.push_back(d);
				issued_words++;
			end
		end
	endtask

	task automatic queue_write(input logic [CfgIdxW-1:0] idx, input int value);
		step_t s;
		s.kind = STEP_WRITE;
		s.idx = idx;
		s.data = value[CfgDataW-1:0];
		s.row = '0;
		s.blk = '0;
		s.idle_pct = 0;
		pending_steps.push_back(s);
		case (idx)
			CfgWidth:  plan_width = value & 16'h7FFF;
			CfgHeight: plan_height = value & 16'h7FFF;
			default: ;
		endcase
	endtask

	task automatic queue_request(input int row, input int blk, input int idle_pct);
		step_t s;
		s.kind = STEP_REQUEST;
		s.idx = '0;
		s.data = '0;
		s.row = row[13:0];
		s.blk = blk[6:0];
		s.idle_pct = idle_pct;
		pending_steps.push_back(s);
	endtask

	task automatic queue_settle();
		step_t s;
		s.kind = STEP_SETTLE;
		s.idx = '0;
		s.data = '0;
		s.row = '0;
		s.blk = '0;
		s.idle_pct = 0;
		pending_steps.push_back(s);
	endtask

	// Driver: hold start while busy, take the next step once the current request is accepted.
	// Register writes and settle steps wait until the block is idle and nothing is owed.
	always @(posedge clk) begin
		logic  accept;
		logic  raise;
		logic  write;
		step_t s;
		if (arst_n) begin
			accept = start && !busy;
			if (accept)
				plan_descriptors(row_index, block_column);
			raise = start && !accept;
			write = 1'b0;
			if (!raise && pending_steps.size() != 0) begin
				s = pending_steps[0];
				case (s.kind)
					STEP_REQUEST: begin
						// Random sender gap before offering the next request.
						if ($urandom_range(99) >= s.idle_pct) begin
							raise = 1'b1;
							row_index <= s.row;
							block_column <= s.blk;
							void'(pending_steps.pop_front());
						end
					end
					STEP_WRITE: begin
						if (!accept && !busy && issued_words == checked_words) begin
							write = 1'b1;
							wr_index <= s.idx;
							wr_data <= s.data;
							case (s.idx)
								CfgWidth:     cfg_width = s.data;
								CfgHeight:    cfg_height = s.data;
								CfgDirection: cfg_tile_dir = s.data[0];
								default: ;  // unused index: the block drops it
							endcase
							void'(pending_steps.pop_front());
						end
					end
					default: begin
						if (!accept && !busy && issued_words == checked_words)
							void'(pending_steps.pop_front());
					end
				endcase
			end
			start <= raise;
			wr_en <= write;
		end
	end

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, want, got);
			errors++;
		end
	endtask

	// Monitor: every strobed word must match the oldest owed descriptor.
	always @(posedge clk) begin
		descriptor_t want;
		if (arst_n && result_strobe) begin
			if (owed_descriptors.size() == 0) begin
				$display("%0t: unexpected word, expected none actual src %0d dst %0d bytes %0d",
					$realtime, source_offset, dest_offset, byte_count);
				errors++;
			end else begin
				want = owed_descriptors.pop_front();
				check_field("source_offset", want.src, source_offset);
				check_field("dest_offset", want.dst, dest_offset);
				check_field("byte_count", want.bytes, byte_count);
				check_field("last_of_run", want.last, last_of_run);
				check_field("bad_request", want.bad, bad_request);
			end
			checked_words <= checked_words + 1;
		end
	end

	// Watchdog on a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int idle_by_phase[4];
		int idle;
		int bpr;
		idle_by_phase = '{0, 47, 0, 38};

		// Directed: reset values first (1x1 surface, detile).
		queue_request(0, 0, 0);        // lone pixel, 4-byte word
		queue_request(1, 0, 0);        // row past the height
		queue_request(0, 1, 0);        // block past the width

		// Largest surface, tile direction, field extremes and alternating bits.
		queue_write(CfgWidth, 16384);
		queue_write(CfgHeight, 16384);
		queue_write(CfgDirection, 1);
		queue_request(0, 0, 0);
		queue_request(16383, 127, 0);
		queue_request(16383, 0, 0);
		queue_request(0, 127, 0);
		queue_request(10922, 85, 0);
		queue_request(5461, 42, 0);
		queue_write(CfgDirection, 0);
		queue_request(127, 3, 0);
		queue_request(128, 1, 0);

		// Odd tail: three pixels in the last block gives a pair then a single.
		queue_write(CfgWidth, 131);
		queue_write(CfgHeight, 300);
		queue_request(299, 1, 0);
		queue_request(300, 0, 0);
		queue_request(5, 2, 0);
		queue_write(CfgWidth, 129);
		queue_request(7, 1, 0);        // one pixel only in the block

		// Extents outside the legal range reject everything; a legal extent is then restored.
		queue_write(CfgWidth, 0);
		queue_request(0, 0, 0);
		queue_write(CfgWidth, 16385);
		queue_request(0, 0, 0);
		queue_write(CfgWidth, 32767);
		queue_write(CfgUnused, 32767); // must leave every register alone
		queue_request(0, 0, 0);
		queue_write(CfgWidth, 255);
		queue_write(CfgHeight, 0);
		queue_request(0, 0, 0);
		queue_write(CfgHeight, 32767);
		queue_request(0, 0, 0);
		queue_write(CfgHeight, 1);
		queue_request(0, 1, 0);

		// Random phases: new geometry each phase, mostly in-surface requests.
		for (int ph = 0; ph < 8; ph++) begin
			idle = idle_by_phase[ph % 4];
			case ($urandom_range(3))
				0:       queue_write(CfgWidth, 16384);
				1:       queue_write(CfgWidth, $urandom_range(300, 1));
				default: queue_write(CfgWidth, $urandom_range(16384, 1));
			endcase
			case ($urandom_range(3))
				0:       queue_write(CfgHeight, 16384);
				1:       queue_write(CfgHeight, $urandom_range(64, 1));
				default: queue_write(CfgHeight, $urandom_range(16384, 1));
			endcase
			queue_write(CfgDirection, $urandom_range(1));
			bpr = (plan_width + TileEdge - 1) / TileEdge;
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(99) < 85)
					queue_request($urandom_range(plan_height - 1, 0), $urandom_range(bpr - 1, 0),
						idle);
				else
					queue_request($urandom_range(16383), $urandom_range(127), idle);
				// Let the block run dry once mid-phase.
				if (k == 30 && ph == 1)
					queue_settle();
			end
		end

		// Reset once, released away from the active edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_steps.size() != 0 || start || issued_words != checked_words);
		repeat (DrainCycles) @(negedge clk);
		if (owed_descriptors.size() != 0) begin
			$display("%0t: %0d descriptor words never arrived, expected 0 actual %0d",
				$realtime, owed_descriptors.size(), owed_descriptors.size());
			errors++;
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/core/dsta_pkg.sv
rtl/core/dsta_ctrl.sv
rtl/core/dsta_datapath.sv
rtl/core/depth_surface_tile_copy_addresser_core.sv
sim/depth_surface_tile_copy_addresser_core_tb.sv
